@@ hw/rtl/udpdmx_pkg.sv @@
// shared types and constants for the udp port demux table
// no dependencies
package udpdmx_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int TRY_W = $clog2(ENTRIES + 2);

	localparam logic [15:0] EPH_LOW_RESET = 16'd4096;
	localparam logic [15:0] EPH_LIMIT_RESET = 16'd32000;
	localparam logic [15:0] LAST_PORT_RESET = 16'd1024;

	localparam logic [2:0] KIND_ALLOC = 3'd0;
	localparam logic [2:0] KIND_FREE = 3'd1;
	localparam logic [2:0] KIND_BIND = 3'd2;
	localparam logic [2:0] KIND_CONNECT = 3'd3;
	localparam logic [2:0] KIND_LOOKUP = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_IN_USE = 3'd2;
	localparam logic [2:0] ST_NO_MATCH = 3'd3;
	localparam logic [2:0] ST_INACTIVE = 3'd4;

	localparam logic REG_EPH_LOW = 1'b0;
	localparam logic REG_EPH_LIMIT = 1'b1;

	typedef struct packed {
		logic [31:0] peer_addr;
		logic [15:0] peer_port;
		logic [15:0] local_port;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CN_RD,
		S_CN_CHK,
		S_PICK,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_WR_RD,
		S_WR_WR,
		S_COMPACT,
		S_LK_RD,
		S_LK_CMP,
		S_DONE
	} state_t;

endpackage

@@ hw/rtl/udpdmx_entry_ram.sv @@
// endpoint entry memory: one write port, one registered read port
// uses udpdmx_pkg; entries never written read as zero
module udpdmx_entry_ram (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [udpdmx_pkg::IDX_W-1:0] rd_addr,
	output udpdmx_pkg::entry_t           rd_data,
	input  logic                         wr_en,
	input  logic [udpdmx_pkg::IDX_W-1:0] wr_addr,
	input  udpdmx_pkg::entry_t           wr_data
);

	udpdmx_pkg::entry_t mem [udpdmx_pkg::ENTRIES];
	udpdmx_pkg::entry_t rd_q;
	logic [udpdmx_pkg::ENTRIES-1:0] written_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= written_q[rd_addr];
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

@@ hw/rtl/udp_port_demux_table.sv @@
// top level of the udp port demux table: control sequencer, lists, registers
// uses udpdmx_pkg and udpdmx_entry_ram
//
// Keeps 16 IPv4 UDP endpoint entries (local port, peer port, peer address) in a
// single-port-read entry memory, plus a free FIFO and an active list in allocation
// order. One operation is handled at a time. Free on an active slot also compacts
// the active list, dropping the freed slot. An explicit bind scans the entry
// memory for its port. Ephemeral port selection tries up to 17 candidates with a
// memory scan each. A lookup reads active entries in list order until a match or
// the end of the list. A new operation is taken while the previous result still
// waits on the output register.
module udp_port_demux_table (
	input  logic        clk,
	input  logic        arst_n,
	// operation input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // slot[3:0], local_port[19:4], remote_port[35:20],
	                              // remote_addr[67:36], has_remote[68], zero fill
	input  logic [2:0]  s_tuser,  // kind[2:0]
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // status[2:0], slot_out[6:3], port_out[22:7], zero fill
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IW = udpdmx_pkg::IDX_W;
	localparam int CW = udpdmx_pkg::CNT_W;
	localparam int TW = udpdmx_pkg::TRY_W;
	localparam int N = udpdmx_pkg::ENTRIES;

	udpdmx_pkg::state_t state_q, state_d;

	// latched operation
	logic [2:0]  kind_q;
	logic [15:0] lport_q, rport_q;
	logic [31:0] raddr_q;
	logic        has_q;

	// working registers
	logic [IW-1:0] tgt_q;
	logic [15:0] newport_q, cand_q, last_q;
	logic [TW-1:0] tries_q;
	logic [IW-1:0] scan_idx_q, lk_idx_q;
	logic        set_peer_q, pick_mode_q;
	logic [CW-1:0] cp_i_q, cp_j_q;

	// list state
	logic [N-1:0]  active_q;
	logic [IW-1:0] free_fifo_q [N];
	logic [IW-1:0] free_head_q;
	logic [CW-1:0] free_count_q;
	logic [IW-1:0] order_q [N];
	logic [CW-1:0] act_count_q;

	logic [15:0] eph_low_q, eph_lim_q;

	// result
	logic [2:0]  res_status_q;
	logic [IW-1:0] res_slot_q;
	logic [15:0] res_port_q;
	logic        m_valid_q;
	logic [2:0]  m_status_q;
	logic [IW-1:0] m_slot_q;
	logic [15:0] m_port_q;

	// entry memory access
	logic [IW-1:0] rd_addr, wr_addr;
	logic        wr_en;
	udpdmx_pkg::entry_t rd_data, wr_data;

	// decoded input
	logic [2:0]  in_kind;
	logic [IW-1:0] in_slot;
	logic [15:0] in_lport;
	logic [2:0]  in_status;
	logic        accept, out_free;
	logic [15:0] next_cand;
	logic        lk_hit, scan_hit, tries_left, lk_last;
	logic [IW-1:0] lk_entry;
	logic [CW-1:0] push_sum;

	assign in_kind = s_tuser;
	assign in_slot = s_tdata[IW-1:0];
	assign in_lport = s_tdata[IW+15:IW];
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	udpdmx_entry_ram u_entry_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// next ephemeral candidate, wrapping at the limit
	always_comb begin
		next_cand = last_q + 16'd1;
		if (next_cand >= eph_lim_q) begin
			next_cand = eph_low_q;
		end
	end

	// status known at accept time; later states refine it
	always_comb begin
		in_status = udpdmx_pkg::ST_NO_MATCH;
		case (in_kind)
			udpdmx_pkg::KIND_ALLOC: begin
				in_status = (free_count_q == '0) ? udpdmx_pkg::ST_FULL : udpdmx_pkg::ST_OK;
			end
			udpdmx_pkg::KIND_FREE: begin
				in_status = active_q[in_slot] ? udpdmx_pkg::ST_OK : udpdmx_pkg::ST_INACTIVE;
			end
			udpdmx_pkg::KIND_BIND, udpdmx_pkg::KIND_CONNECT: begin
				if (!active_q[in_slot]) begin
					in_status = udpdmx_pkg::ST_INACTIVE;
				end
			end
			default: ;
		endcase
	end

	assign lk_entry = order_q[lk_idx_q];
	assign lk_hit = (rd_data.local_port != 16'd0) && (rd_data.local_port == lport_q) &&
		((rd_data.peer_port == 16'd0) || (rd_data.peer_port == rport_q)) &&
		((rd_data.peer_addr == 32'd0) || (rd_data.peer_addr == 32'hFFFF_FFFF) ||
		 (rd_data.peer_addr == raddr_q));
	assign lk_last = (CW'(lk_idx_q) + CW'(1)) == act_count_q;
	assign scan_hit = rd_data.local_port == cand_q;
	assign tries_left = pick_mode_q && (tries_q != TW'(N + 1));
	assign push_sum = CW'(free_head_q) + free_count_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			udpdmx_pkg::S_IDLE: begin
				if (accept) begin
					case (in_kind)
						udpdmx_pkg::KIND_ALLOC: begin
							state_d = (free_count_q == '0) ? udpdmx_pkg::S_DONE
								: udpdmx_pkg::S_WR_RD;
						end
						udpdmx_pkg::KIND_FREE: begin
							state_d = active_q[in_slot] ? udpdmx_pkg::S_WR_RD
								: udpdmx_pkg::S_DONE;
						end
						udpdmx_pkg::KIND_BIND: begin
							if (!active_q[in_slot]) begin
								state_d = udpdmx_pkg::S_DONE;
							end else if (in_lport == 16'd0) begin
								state_d = udpdmx_pkg::S_PICK;
							end else begin
								state_d = udpdmx_pkg::S_SCAN_RD;
							end
						end
						udpdmx_pkg::KIND_CONNECT: begin
							state_d = active_q[in_slot] ? udpdmx_pkg::S_CN_RD
								: udpdmx_pkg::S_DONE;
						end
						udpdmx_pkg::KIND_LOOKUP: begin
							state_d = (act_count_q == '0) ? udpdmx_pkg::S_DONE
								: udpdmx_pkg::S_LK_RD;
						end
						default: state_d = udpdmx_pkg::S_DONE;
					endcase
				end
			end
			udpdmx_pkg::S_CN_RD: state_d = udpdmx_pkg::S_CN_CHK;
			udpdmx_pkg::S_CN_CHK: begin
				state_d = (rd_data.local_port != 16'd0) ? udpdmx_pkg::S_WR_RD
					: udpdmx_pkg::S_PICK;
			end
			udpdmx_pkg::S_PICK: begin
				if (next_cand != 16'd0) begin
					state_d = udpdmx_pkg::S_SCAN_RD;
				end else if (tries_q + TW'(1) == TW'(N + 1)) begin
					state_d = udpdmx_pkg::S_DONE;
				end
			end
			udpdmx_pkg::S_SCAN_RD: state_d = udpdmx_pkg::S_SCAN_CMP;
			udpdmx_pkg::S_SCAN_CMP: begin
				if (scan_hit) begin
					state_d = tries_left ? udpdmx_pkg::S_PICK : udpdmx_pkg::S_DONE;
				end else if (scan_idx_q == IW'(N - 1)) begin
					state_d = udpdmx_pkg::S_WR_RD;
				end else begin
					state_d = udpdmx_pkg::S_SCAN_RD;
				end
			end
			udpdmx_pkg::S_WR_RD: state_d = udpdmx_pkg::S_WR_WR;
			udpdmx_pkg::S_WR_WR: begin
				state_d = (kind_q == udpdmx_pkg::KIND_FREE) ? udpdmx_pkg::S_COMPACT
					: udpdmx_pkg::S_DONE;
			end
			udpdmx_pkg::S_COMPACT: begin
				state_d = (cp_i_q == act_count_q) ? udpdmx_pkg::S_DONE
					: udpdmx_pkg::S_COMPACT;
			end
			udpdmx_pkg::S_LK_RD: state_d = udpdmx_pkg::S_LK_CMP;
			udpdmx_pkg::S_LK_CMP: begin
				state_d = (lk_hit || lk_last) ? udpdmx_pkg::S_DONE : udpdmx_pkg::S_LK_RD;
			end
			udpdmx_pkg::S_DONE: state_d = out_free ? udpdmx_pkg::S_IDLE : udpdmx_pkg::S_DONE;
			default: state_d = udpdmx_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		rd_addr = tgt_q;
		wr_en = 1'b0;
		wr_addr = tgt_q;
		wr_data.local_port = newport_q;
		wr_data.peer_port = rd_data.peer_port;
		wr_data.peer_addr = rd_data.peer_addr;
		if (set_peer_q) begin
			wr_data.peer_port = has_q ? rport_q : 16'd0;
			wr_data.peer_addr = has_q ? raddr_q : 32'd0;
		end
		case (state_q)
			udpdmx_pkg::S_IDLE: s_tready = 1'b1;
			udpdmx_pkg::S_SCAN_RD: rd_addr = scan_idx_q;
			udpdmx_pkg::S_LK_RD: rd_addr = lk_entry;
			udpdmx_pkg::S_WR_WR: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= udpdmx_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// operation payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_kind;
			lport_q <= in_lport;
			rport_q <= s_tdata[IW+31:IW+16];
			raddr_q <= s_tdata[IW+63:IW+32];
			has_q <= s_tdata[IW+64];
		end
	end

	// datapath and list control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= '0;
			newport_q <= '0;
			cand_q <= '0;
			last_q <= udpdmx_pkg::LAST_PORT_RESET;
			tries_q <= '0;
			scan_idx_q <= '0;
			lk_idx_q <= '0;
			set_peer_q <= 1'b0;
			pick_mode_q <= 1'b0;
			cp_i_q <= '0;
			cp_j_q <= '0;
			active_q <= '0;
			for (int k = 0; k < N; k++) begin
				free_fifo_q[k] <= IW'(k);
				order_q[k] <= '0;
			end
			free_head_q <= '0;
			free_count_q <= CW'(N);
			act_count_q <= '0;
			eph_low_q <= udpdmx_pkg::EPH_LOW_RESET;
			eph_lim_q <= udpdmx_pkg::EPH_LIMIT_RESET;
			res_status_q <= udpdmx_pkg::ST_NO_MATCH;
			res_slot_q <= '0;
			res_port_q <= '0;
			m_valid_q <= 1'b0;
			m_status_q <= '0;
			m_slot_q <= '0;
			m_port_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == udpdmx_pkg::REG_EPH_LOW) begin
					eph_low_q <= cfg_data;
				end else begin
					eph_lim_q <= cfg_data;
				end
			end

			// result register: load from done, otherwise drain on a transfer
			if (state_q == udpdmx_pkg::S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				udpdmx_pkg::S_IDLE: begin
					if (accept) begin
						res_status_q <= in_status;
						res_port_q <= '0;
						newport_q <= '0;
						tries_q <= '0;
						scan_idx_q <= '0;
						lk_idx_q <= '0;
						cp_i_q <= '0;
						cp_j_q <= '0;
						cand_q <= in_lport;
						set_peer_q <= in_kind == udpdmx_pkg::KIND_CONNECT;
						// explicit port: a single scan, no retry
						pick_mode_q <= !(in_kind == udpdmx_pkg::KIND_BIND &&
							in_lport != 16'd0);
						if (in_kind == udpdmx_pkg::KIND_ALLOC && free_count_q != '0) begin
							tgt_q <= free_fifo_q[free_head_q];
							res_slot_q <= free_fifo_q[free_head_q];
						end else begin
							tgt_q <= in_slot;
							res_slot_q <= '0;
						end
						case (in_kind)
							udpdmx_pkg::KIND_ALLOC: begin
								if (free_count_q != '0) begin
									free_head_q <= free_head_q + IW'(1);
									free_count_q <= free_count_q - CW'(1);
									active_q[free_fifo_q[free_head_q]] <= 1'b1;
									if (act_count_q < CW'(N)) begin
										order_q[act_count_q[IW-1:0]] <= free_fifo_q[free_head_q];
										act_count_q <= act_count_q + CW'(1);
									end
								end
							end
							udpdmx_pkg::KIND_FREE: begin
								if (active_q[in_slot]) begin
									active_q[in_slot] <= 1'b0;
									if (free_count_q < CW'(N)) begin
										free_fifo_q[push_sum[IW-1:0]] <= in_slot;
										free_count_q <= free_count_q + CW'(1);
									end
								end
							end
							default: ;
						endcase
					end
				end
				udpdmx_pkg::S_CN_CHK: begin
					if (rd_data.local_port != 16'd0) begin
						newport_q <= rd_data.local_port;
						res_status_q <= udpdmx_pkg::ST_OK;
						res_port_q <= rd_data.local_port;
					end
				end
				udpdmx_pkg::S_PICK: begin
					last_q <= next_cand;
					cand_q <= next_cand;
					tries_q <= tries_q + TW'(1);
					scan_idx_q <= '0;
					// candidate zero counts as used
					if (next_cand == 16'd0 && tries_q + TW'(1) == TW'(N + 1)) begin
						res_status_q <= udpdmx_pkg::ST_IN_USE;
					end
				end
				udpdmx_pkg::S_SCAN_CMP: begin
					if (scan_hit) begin
						if (!tries_left) begin
							res_status_q <= udpdmx_pkg::ST_IN_USE;
						end
					end else if (scan_idx_q == IW'(N - 1)) begin
						newport_q <= cand_q;
						res_status_q <= udpdmx_pkg::ST_OK;
						res_port_q <= cand_q;
					end else begin
						scan_idx_q <= scan_idx_q + IW'(1);
					end
				end
				udpdmx_pkg::S_COMPACT: begin
					// squeeze the freed slot out of the active list
					if (cp_i_q == act_count_q) begin
						act_count_q <= cp_j_q;
					end else begin
						if (order_q[cp_i_q[IW-1:0]] != tgt_q) begin
							order_q[cp_j_q[IW-1:0]] <= order_q[cp_i_q[IW-1:0]];
							cp_j_q <= cp_j_q + CW'(1);
						end
						cp_i_q <= cp_i_q + CW'(1);
					end
				end
				udpdmx_pkg::S_LK_CMP: begin
					if (lk_hit) begin
						res_status_q <= udpdmx_pkg::ST_OK;
						res_slot_q <= lk_entry;
						res_port_q <= rd_data.local_port;
					end else begin
						lk_idx_q <= lk_idx_q + IW'(1);
					end
				end
				udpdmx_pkg::S_DONE: begin
					if (out_free) begin
						m_status_q <= res_status_q;
						m_slot_q <= res_slot_q;
						m_port_q <= res_port_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, m_port_q, m_slot_q, m_status_q};

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the udp port demux table
// depends on udpdmx_pkg and the udp_port_demux_table rtl
// drives operations, predicts each result from a local copy of the table, compares field by field
`timescale 1ns / 1ps

module testbench;
	import udpdmx_pkg::*;

	localparam logic [2:0] KIND_UNUSED_FIRST = KIND_LOOKUP + 3'd1;
	localparam logic [2:0] KIND_UNUSED_LAST = 3'd7;

	// one operation as it travels on the input stream
	typedef struct {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [15:0] lport;
		logic [15:0] rport;
		logic [31:0] raddr;
		logic        has_peer;
	} table_op_t;

	// one result as the output stream carries it
	typedef struct {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [15:0] port;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;  // slot, local_port, remote_port, remote_addr, has_remote
	logic [2:0]  s_tuser = '0;  // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // status, slot_out, port_out
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	table_op_t     pending_ops[$];
	table_result_t expected_results[$];
	int            errors = 0;
	int            send_idle_pct = 28;
	int            recv_idle_pct = 55;
	logic          hold_rx = 1'b0;

	// local copy of the endpoint table
	logic [15:0] mdl_local[ENTRIES];
	logic [15:0] mdl_peer_port[ENTRIES];
	logic [31:0] mdl_peer_addr[ENTRIES];
	logic        mdl_active[ENTRIES];
	logic [3:0]  mdl_free_fifo[ENTRIES];
	logic [3:0]  mdl_free_head;
	int          mdl_free_count;
	logic [3:0]  mdl_order[ENTRIES];
	int          mdl_order_count;
	logic [15:0] mdl_last_port;
	logic [15:0] mdl_eph_low;
	logic [15:0] mdl_eph_limit;

	udp_port_demux_table DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic bit port_taken(logic [15:0] p);
		if (p == 16'd0)
			return 1'b1;
		for (int i = 0; i < ENTRIES; i++)
			if (mdl_local[i] == p)
				return 1'b1;
		return 1'b0;
	endfunction

	// ephemeral search: at most ENTRIES+1 candidates, the cursor keeps advancing
	function automatic bit choose_ephemeral(output logic [15:0] port);
		logic [15:0] cand;
		port = '0;
		for (int t = 0; t < ENTRIES + 1; t++) begin
			cand = mdl_last_port + 16'd1;
			if (cand >= mdl_eph_limit)
				cand = mdl_eph_low;
			mdl_last_port = cand;
			if (!port_taken(cand)) begin
				port = cand;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void reset_table();
		for (int i = 0; i < ENTRIES; i++) begin
			mdl_local[i] = '0;
			mdl_peer_port[i] = '0;
			mdl_peer_addr[i] = '0;
			mdl_active[i] = 1'b0;
			mdl_free_fifo[i] = i[3:0];
			mdl_order[i] = '0;
		end
		mdl_free_head = '0;
		mdl_free_count = ENTRIES;
		mdl_order_count = 0;
		mdl_last_port = LAST_PORT_RESET;
		mdl_eph_low = EPH_LOW_RESET;
		mdl_eph_limit = EPH_LIMIT_RESET;
	endfunction

	// applies one accepted operation to the local table and returns its result
	function automatic table_result_t table_predict(table_op_t op);
		table_result_t r;
		logic [3:0]    s;
		logic [3:0]    e;
		logic [15:0]   p;
		bit            ok;
		int            j;
		r.status = ST_NO_MATCH;
		r.slot = '0;
		r.port = '0;
		s = op.slot;
		if (op.kind == KIND_ALLOC) begin
			if (mdl_free_count == 0) begin
				r.status = ST_FULL;
			end else begin
				e = mdl_free_fifo[mdl_free_head];
				mdl_free_head = mdl_free_head + 4'd1;
				mdl_free_count--;
				mdl_local[e] = '0;
				mdl_active[e] = 1'b1;
				if (mdl_order_count < ENTRIES)
					mdl_order[mdl_order_count++] = e;
				r.status = ST_OK;
				r.slot = e;
			end
		end else if (op.kind inside {KIND_FREE, KIND_BIND, KIND_CONNECT} && !mdl_active[s]) begin
			r.status = ST_INACTIVE;
		end else if (op.kind == KIND_FREE) begin
			mdl_local[s] = '0;
			mdl_active[s] = 1'b0;
			j = 0;
			for (int i = 0; i < mdl_order_count; i++)
				if (mdl_order[i] != s)
					mdl_order[j++] = mdl_order[i];
			mdl_order_count = j;
			if (mdl_free_count < ENTRIES) begin
				mdl_free_fifo[(mdl_free_head + mdl_free_count) % ENTRIES] = s;
				mdl_free_count++;
			end
			r.status = ST_OK;
		end else if (op.kind == KIND_BIND) begin
			if (op.lport == 16'd0) begin
				if (choose_ephemeral(p)) begin
					mdl_local[s] = p;
					r.status = ST_OK;
					r.port = p;
				end else begin
					r.status = ST_IN_USE;
				end
			end else if (port_taken(op.lport)) begin
				r.status = ST_IN_USE;
			end else begin
				mdl_local[s] = op.lport;
				r.status = ST_OK;
				r.port = op.lport;
			end
		end else if (op.kind == KIND_CONNECT) begin
			p = mdl_local[s];
			ok = 1'b1;
			if (p == 16'd0) begin
				ok = choose_ephemeral(p);
				if (ok)
					mdl_local[s] = p;
			end
			if (ok) begin
				mdl_peer_port[s] = op.has_peer ? op.rport : 16'd0;
				mdl_peer_addr[s] = op.has_peer ? op.raddr : 32'd0;
				r.status = ST_OK;
				r.port = p;
			end else begin
				r.status = ST_IN_USE;
			end
		end else if (op.kind == KIND_LOOKUP) begin
			for (int i = 0; i < mdl_order_count; i++) begin
				e = mdl_order[i];
				if (mdl_local[e] != 16'd0 && mdl_local[e] == op.lport &&
				    (mdl_peer_port[e] == 16'd0 || mdl_peer_port[e] == op.rport) &&
				    (mdl_peer_addr[e] == 32'd0 || mdl_peer_addr[e] == 32'hFFFF_FFFF ||
				     mdl_peer_addr[e] == op.raddr)) begin
					r.status = ST_OK;
					r.slot = e;
					r.port = mdl_local[e];
					break;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		errors++;
	endtask

	// driver: a new transfer may be offered when the line is free or the last one was taken
	always @(posedge clk or negedge arst_n) begin
		table_op_t op;
		table_op_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				op.kind = s_tuser;
				op.slot = s_tdata[3:0];
				op.lport = s_tdata[19:4];
				op.rport = s_tdata[35:20];
				op.raddr = s_tdata[67:36];
				op.has_peer = s_tdata[68];
				expected_results.push_back(table_predict(op));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nxt.kind;
					s_tdata <= {3'b0, nxt.has_peer, nxt.raddr, nxt.rport, nxt.lport, nxt.slot};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, held low for the whole stretch while hold_rx is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: every result transfer is checked against the oldest prediction
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("result transfer with nothing expected");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[2:0] != want.status)
					report_mismatch("status", m_tdata[2:0], want.status);
				if (m_tdata[6:3] != want.slot)
					report_mismatch("slot_out", m_tdata[6:3], want.slot);
				if (m_tdata[22:7] != want.port)
					report_mismatch("port_out", m_tdata[22:7], want.port);
			end
		end
	end

	function automatic table_op_t make_op(logic [2:0] kind, logic [3:0] slot,
	                                      logic [15:0] lport, logic [15:0] rport,
	                                      logic [31:0] raddr, logic has_peer);
		table_op_t op;
		op.kind = kind;
		op.slot = slot;
		op.lport = lport;
		op.rport = rport;
		op.raddr = raddr;
		op.has_peer = has_peer;
		return op;
	endfunction

	// ports mostly from a small pool so binds collide and lookups hit
	function automatic logic [15:0] pool_port(logic [15:0] eph_low);
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return 16'(53 + 10 * $urandom_range(5));
		if (r < 75)
			return eph_low + 16'($urandom_range(20));
		if (r < 85)
			return 16'd0;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] peer_port_pick();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'd7;
			2: return 16'hFFFF;
			3: return 16'd1000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] peer_addr_pick();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0A00_0001;
			3: return 32'h0A00_0002;
			default: return $urandom;
		endcase
	endfunction

	function automatic table_op_t random_op(logic [15:0] eph_low);
		int          r;
		logic [2:0]  kind;
		logic [15:0] lport;
		r = $urandom_range(99);
		if (r < 24)
			kind = KIND_ALLOC;
		else if (r < 40)
			kind = KIND_FREE;
		else if (r < 60)
			kind = KIND_BIND;
		else if (r < 75)
			kind = KIND_CONNECT;
		else if (r < 97)
			kind = KIND_LOOKUP;
		else
			kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
		lport = pool_port(eph_low);
		if (kind == KIND_BIND && $urandom_range(99) < 45)
			lport = 16'd0;
		return make_op(kind, 4'($urandom), lport, peer_port_pick(), peer_addr_pick(),
			1'($urandom));
	endfunction

	task automatic wait_drained();
		@(posedge clk);
		while (pending_ops.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic index, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (index == REG_EPH_LOW)
			mdl_eph_low = value;
		else
			mdl_eph_limit = value;
	endtask

	task automatic random_phase(int count, logic [15:0] low, logic [15:0] limit);
		wait_drained();
		write_reg(REG_EPH_LOW, low);
		write_reg(REG_EPH_LIMIT, limit);
		for (int i = 0; i < count; i++)
			pending_ops.push_back(random_op(low));
	endtask

	initial begin
		reset_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, inactive slots, unknown kinds, fill to full
		pending_ops.push_back(make_op(KIND_LOOKUP, 4'd0, 16'd80, 16'd1, 32'd1, 1'b0));
		pending_ops.push_back(make_op(KIND_FREE, 4'd3, '0, '0, '0, 1'b0));
		pending_ops.push_back(make_op(KIND_BIND, 4'd15, 16'd80, '0, '0, 1'b0));
		pending_ops.push_back(make_op(KIND_CONNECT, 4'd0, '0, 16'd9, 32'd9, 1'b1));
		for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
			pending_ops.push_back(make_op(3'(k), 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
				1'b1));
		for (int i = 0; i < ENTRIES + 1; i++)
			pending_ops.push_back(make_op(KIND_ALLOC, '0, '0, '0, '0, 1'b0));
		// ephemeral bind, explicit binds, then a repeated explicit bind that collides
		pending_ops.push_back(make_op(KIND_BIND, 4'd0, 16'd0, '0, '0, 1'b0));
		pending_ops.push_back(make_op(KIND_BIND, 4'd1, 16'd4097, '0, '0, 1'b0));
		pending_ops.push_back(make_op(KIND_BIND, 4'd1, 16'hFFFF, '0, '0, 1'b0));
		pending_ops.push_back(make_op(KIND_BIND, 4'd1, 16'hFFFF, '0, '0, 1'b0));
		// connect on an unbound entry picks a port; connect with a peer on a bound one
		pending_ops.push_back(make_op(KIND_CONNECT, 4'd2, '0, '0, '0, 1'b0));
		pending_ops.push_back(make_op(KIND_CONNECT, 4'd1, '0, 16'd5000, 32'hC0A8_0001, 1'b1));
		pending_ops.push_back(make_op(KIND_LOOKUP, '0, 16'hFFFF, 16'd5000, 32'hC0A8_0001,
			1'b0));
		pending_ops.push_back(make_op(KIND_LOOKUP, '0, 16'hFFFF, 16'd5001, 32'hC0A8_0001,
			1'b0));
		// connect with a broadcast peer address, then a lookup on a port that no entry holds
		pending_ops.push_back(make_op(KIND_CONNECT, 4'd0, '0, 16'd0, 32'hFFFF_FFFF, 1'b1));
		pending_ops.push_back(make_op(KIND_LOOKUP, '0, 16'd4097, 16'hFFFF, 32'h1234_5678,
			1'b0));
		// free keeps peer fields; reallocation takes the freed slot back from the fifo head
		pending_ops.push_back(make_op(KIND_FREE, 4'd1, '0, '0, '0, 1'b0));
		pending_ops.push_back(make_op(KIND_ALLOC, '0, '0, '0, '0, 1'b0));
		pending_ops.push_back(make_op(KIND_LOOKUP, '0, 16'd0, 16'd0, 32'd0, 1'b0));
		for (int i = 0; i < 330; i++)
			pending_ops.push_back(random_op(EPH_LOW_RESET));

		// lowest range: every ephemeral candidate is port 1
		random_phase(200, 16'd1, 16'd2);
		send_idle_pct = 55;
		recv_idle_pct = 28;

		// top of the port range, with a long receiver stall in its own process
		random_phase(200, 16'hFFFF, 16'hFFFF);
		fork
			begin : rx_stall
				hold_rx <= 1'b1;
				repeat (3000) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none

		// narrow range that runs out of ports, then a wide high one
		random_phase(300, 16'd100, 16'd110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(300, 16'd60000, 16'hFFFF);

		wait_drained();
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
